[hw/rtl/ris_pkg.sv]
package ris_pkg;

	localparam int MAX_RECORDS = 32;
	localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CW = $clog2(MAX_RECORDS + 1);

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] count_t;

	typedef struct packed {
		logic [30:0] sales_amount;
		logic [15:0] record_tag;
		logic        last_record;
	} ris_req_t;

	typedef struct packed {
		logic [30:0] sorted_amount;
		logic [15:0] sorted_tag;
		logic        last_out;
		logic        overflowed;
	} ris_rsp_t;

	typedef struct packed {
		logic [30:0] amount;
		logic [15:0] tag;
	} ris_rec_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_EMIT_RD,
		ST_EMIT
	} ris_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic set_ovf;
		logic shift_step;
		logic place;
		logic emit_start;
		logic emit_step;
		logic clear;
	} ris_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic pos_zero;
		logic key_gt;
		logic idx_zero;
		logic last_q;
	} ris_sts_t;

endpackage

[hw/rtl/ris_ctrl.sv]
module ris_ctrl import ris_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     last_in,
	input  ris_sts_t sts,
	output ris_cmd_t cmd,
	output logic     busy
);

	ris_state_t state_q;
	ris_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (!sts.full) begin
						state_d = ST_INSERT;
					end else if (last_in) begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			ST_INSERT: begin
				if (sts.pos_zero || !sts.key_gt) begin
					state_d = sts.last_q ? ST_EMIT_RD : ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.idx_zero) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load    = 1'b1;
					cmd.set_ovf = sts.full;
				end
			end
			ST_INSERT: begin
				if (!sts.pos_zero && sts.key_gt) begin
					cmd.shift_step = 1'b1;
				end else begin
					cmd.place = 1'b1;
				end
			end
			ST_EMIT_RD: begin
				cmd.emit_start = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit_step = 1'b1;
				cmd.clear     = sts.idx_zero;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[hw/rtl/ris_dp.sv]
module ris_dp import ris_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ris_req_t req,
	input  ris_cmd_t cmd,
	output ris_sts_t sts,
	output ris_rsp_t result,
	output logic     strobe
);

	ris_rec_t mem [MAX_RECORDS];
	ris_rec_t rd_q;
	ris_rec_t new_q;
	logic     last_q;
	addr_t    pos_q;
	addr_t    idx_q;
	count_t   count_q;
	logic     ovf_q;
	ris_rsp_t result_q;
	logic     strobe_q;

	addr_t    rd_addr;
	addr_t    count_m1;
	logic     wr_en;
	ris_rec_t wr_data;

	assign count_m1 = addr_t'(count_q - count_t'(1));

	always_comb begin
		if (cmd.load || cmd.emit_start) begin
			rd_addr = count_m1;
		end else if (cmd.shift_step) begin
			rd_addr = pos_q - addr_t'(2);
		end else begin
			rd_addr = idx_q - addr_t'(1);
		end
	end

	assign wr_en   = cmd.shift_step || cmd.place;
	assign wr_data = cmd.shift_step ? rd_q : new_q;

	// Record store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_q.amount <= req.sales_amount;
			new_q.tag    <= req.record_tag;
			last_q       <= req.last_record;
			pos_q        <= addr_t'(count_q);
		end else if (cmd.shift_step) begin
			pos_q <= pos_q - addr_t'(1);
		end
		if (cmd.emit_start) begin
			idx_q <= count_m1;
		end else if (cmd.emit_step) begin
			idx_q <= idx_q - addr_t'(1);
		end
		if (cmd.emit_step) begin
			result_q.sorted_amount <= rd_q.amount;
			result_q.sorted_tag    <= rd_q.tag;
			result_q.last_out      <= (idx_q == '0);
			result_q.overflowed    <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_step;
			if (cmd.clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (cmd.place) begin
					count_q <= count_q + count_t'(1);
				end
				if (cmd.set_ovf) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	assign sts.full     = (count_q == count_t'(MAX_RECORDS));
	assign sts.pos_zero = (pos_q == '0);
	assign sts.key_gt   = (rd_q.amount > new_q.amount);
	assign sts.idx_zero = (idx_q == '0);
	assign sts.last_q   = last_q;

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

[hw/rtl/record_insertion_sorter.sv]
// A request is taken when start is high and busy is low; busy then stays high while the
// stored records larger than the new one, at most MAX_RECORDS - 1, move up and it is placed.
// A full store drops the new record and sets the overflow flag. A last request then keeps busy
// high to read out the n stored records largest first, one per cycle, after any insertion.
// The result strobe lasts one cycle per record; the receiver cannot stall the output.
// Reset clears the record count, the overflow flag and the controller; the store is not cleared.
module record_insertion_sorter import ris_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  ris_req_t req,
	output ris_rsp_t result,
	output logic     strobe
);

	// The controller sequences each request. An insertion walks the store from the
	// top down, one entry per cycle, moving each larger record up one slot until the
	// new record finds its place. The compare always uses the word read in the
	// previous cycle, so the walk needs no extra read cycles.
	ris_cmd_t cmd;
	ris_sts_t sts;

	ris_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.last_in (req.last_record),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy)
	);

	// The datapath holds the record memory, the count, the overflow flag and the
	// output register. The readout walks from the highest slot down to slot zero, so
	// among equal amounts the record loaded later comes out first.
	ris_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.result (result),
		.strobe (strobe)
	);

endmodule

[verif/sort_checker.sv]
`timescale 1ns / 1ps

// Watches the request and result channels of the sorter, keeps its own
// sorted copy of the records of the open set, and compares every result.
module sort_checker import ris_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  ris_req_t    req,
	input  ris_rsp_t    result,
	input  logic        strobe,
	output int unsigned fail_count,
	output int unsigned pending
);

	// Records of the open set, ascending by amount, equal amounts in arrival order.
	ris_rec_t    held_recs [MAX_RECORDS];
	int          held_count;
	logic        held_ovf;
	ris_rsp_t    sorted_out [$];
	ris_rsp_t    want;
	int unsigned errors;

	assign fail_count = errors;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t ns: %s", $time, msg);
	endtask

	// Places one record after all held records with an equal or smaller amount.
	// A last request then flushes the set, largest amount first.
	task automatic absorb_request(input ris_req_t r);
		int pos;
		int k;
		ris_rsp_t rsp;
		if (held_count >= MAX_RECORDS) begin
			held_ovf = 1'b1;
		end else begin
			pos = held_count;
			while (pos > 0 && held_recs[pos-1].amount > r.sales_amount) begin
				held_recs[pos] = held_recs[pos-1];
				pos--;
			end
			held_recs[pos].amount = r.sales_amount;
			held_recs[pos].tag = r.record_tag;
			held_count++;
		end
		if (r.last_record) begin
			for (k = held_count - 1; k >= 0; k--) begin
				rsp.sorted_amount = held_recs[k].amount;
				rsp.sorted_tag = held_recs[k].tag;
				rsp.last_out = (k == 0);
				rsp.overflowed = held_ovf;
				sorted_out.push_back(rsp);
			end
			held_count = 0;
			held_ovf = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			held_ovf = 1'b0;
			sorted_out.delete();
			pending <= 0;
		end else begin
			if (strobe !== 1'b0) begin
				if (sorted_out.size() == 0) begin
					report_mismatch($sformatf("result with none expected: amount %0h tag %0h",
						result.sorted_amount, result.sorted_tag));
				end else begin
					want = sorted_out.pop_front();
					if (result.sorted_amount !== want.sorted_amount)
						report_mismatch($sformatf("sorted_amount got %0h expected %0h",
							result.sorted_amount, want.sorted_amount));
					if (result.sorted_tag !== want.sorted_tag)
						report_mismatch($sformatf("sorted_tag got %0h expected %0h",
							result.sorted_tag, want.sorted_tag));
					if (result.last_out !== want.last_out)
						report_mismatch($sformatf("last_out got %b expected %b",
							result.last_out, want.last_out));
					if (result.overflowed !== want.overflowed)
						report_mismatch($sformatf("overflowed got %b expected %b",
							result.overflowed, want.overflowed));
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				absorb_request(req);
			pending <= sorted_out.size();
		end
	end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
	import ris_pkg::*;

	// Size of the random part in requests, and the length of the quiet tail
	// at its end; sets that start within the tail never pause.
	localparam int RANDOM_ITEMS = 220;
	localparam int QUIET_TAIL = 40;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	ris_req_t    req;
	ris_rsp_t    result;
	logic        strobe;
	int unsigned fail_count;
	int unsigned pending;

	// Sender pauses are allowed while this is set; the random part turns it
	// off for whole sets to get stretches of back-to-back requests.
	bit gaps_on;
	int items_sent;

	record_insertion_sorter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.result (result),
		.strobe (strobe)
	);

	sort_checker u_sort_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.result     (result),
		.strobe     (strobe),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs or never emits an expected result.
	// The slowest correct run stays well below a tenth of this.
	initial begin
		#7_200_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Amounts lean toward a tiny range so that equal keys are common and the
	// stable ordering gets exercised; the rest are extremes or full-width.
	function automatic logic [30:0] pick_amount();
		int unsigned mode;
		mode = $urandom_range(0, 9);
		if (mode < 4)
			return 31'($urandom_range(0, 7));
		if (mode == 4)
			return ($urandom_range(0, 1) != 0) ? '1 : '0;
		return 31'($urandom);
	endfunction

	// Offers one request and holds it until the block takes it. Before the
	// request the sender may pause, with junk on the payload and start low.
	// Start is written once per clock step, so a request that follows an
	// accepted one keeps start high without a glitch.
	task automatic send_record(input logic [30:0] amount, input logic [15:0] tag,
		input logic last);
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			req <= 48'({$urandom, $urandom});
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		start <= 1'b1;
		req.sales_amount <= amount;
		req.record_tag <= tag;
		req.last_record <= last;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		items_sent++;
	endtask

	initial begin
		int set_idx;
		int set_len;
		int k;
		int pick;

		start <= 1'b0;
		req <= '0;
		arst_n <= 1'b0;
		gaps_on = 1'b0;
		items_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A set of one record at the top of both ranges, and
		// another at the bottom, check that a last request on an empty store
		// is stored before the flush.
		gaps_on = 1'b1;
		send_record('1, 16'hFFFF, 1'b1);
		send_record('0, 16'h0000, 1'b1);

		// Four equal amounts: they must come back in reverse arrival order.
		gaps_on = 1'b0;
		send_record(31'd5, 16'd1, 1'b0);
		send_record(31'd5, 16'd2, 1'b0);
		send_record(31'd5, 16'd3, 1'b0);
		send_record(31'd5, 16'd4, 1'b1);

		// Mixed order with repeated extremes, so records get shifted from both
		// ends of the store and equal keys meet in the middle.
		gaps_on = 1'b1;
		send_record(31'd100, 16'h0101, 1'b0);
		send_record('1, 16'h0202, 1'b0);
		send_record('0, 16'h0303, 1'b0);
		send_record(31'd100, 16'h0404, 1'b0);
		send_record(31'd50, 16'h0505, 1'b0);
		send_record('1, 16'h0606, 1'b0);
		send_record('0, 16'h0707, 1'b0);
		send_record(31'd1, 16'h0808, 1'b1);

		// Alternating bit patterns on every payload bit.
		send_record(31'h2AAAAAAA, 16'h5555, 1'b0);
		send_record(31'h55555555, 16'hAAAA, 1'b1);

		// Random part, made of whole sets. The first set overflows the store by
		// one, so its last request is dropped yet still flushes the set with
		// the overflow mark; the second fills the store exactly. After that
		// most sets are small, with an occasional full or overflowing one.
		items_sent = 0;
		set_idx = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (set_idx == 0) begin
				set_len = MAX_RECORDS + 1;
			end else if (set_idx == 1) begin
				set_len = MAX_RECORDS;
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					set_len = MAX_RECORDS + $urandom_range(1, 4);
				else if (pick == 1)
					set_len = MAX_RECORDS;
				else if (pick < 5)
					set_len = $urandom_range(9, MAX_RECORDS - 1);
				else
					set_len = $urandom_range(1, 8);
			end
			gaps_on = (items_sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			for (k = 0; k < set_len; k++)
				send_record(pick_amount(), 16'($urandom_range(0, 65535)), k == set_len - 1);
			set_idx++;
		end

		// Drain: drop start, let the checker count the final set, then wait for
		// every result and allow room for any stray strobe after the last one.
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/ris_pkg.sv
hw/rtl/ris_ctrl.sv
hw/rtl/ris_dp.sv
hw/rtl/record_insertion_sorter.sv
verif/sort_checker.sv
verif/tb.sv
